/* design/ted_pkg.sv */
// ----------------------------------------------------------------------------
// ted_pkg
// Shared types, verdict codes and lead-byte decode for the encoding detector.
// ----------------------------------------------------------------------------
package ted_pkg;

    typedef enum logic [2:0] {
        ENC_ANSI     = 3'd0,
        ENC_UTF8     = 3'd1,
        ENC_UTF8_BOM = 3'd2,
        ENC_UTF16_LE = 3'd3,
        ENC_UTF16_BE = 3'd4
    } t_enc;

    localparam logic [2:0] COUNT_SAT = 3'd4;

    // Scan state carried from byte to byte within one buffer
    typedef struct packed {
        logic [2:0] pend;       // continuation bytes still owed
        logic       all_ascii;
        logic       invalid;
        logic [7:0] lead0;
        logic [7:0] lead1;
        logic [7:0] lead2;
        logic [2:0] count;      // bytes seen, saturates at COUNT_SAT
    } t_scan;

    localparam t_scan SCAN_RST = '{
        pend:      3'd0,
        all_ascii: 1'b1,
        invalid:   1'b0,
        lead0:     8'h00,
        lead1:     8'h00,
        lead2:     8'h00,
        count:     3'd0
    };

    // Continuations owed after a lead byte; zero means not a valid lead.
    // FE/FF decode as five-byte leads (four continuations).
    function automatic logic [2:0] cont_for_lead(input logic [7:0] b);
        logic [2:0] n;
        if (b == 8'hFC || b == 8'hFD) begin
            n = 3'd5;
        end else if (b >= 8'hF8) begin
            n = 3'd4;
        end else if (b >= 8'hF0) begin
            n = 3'd3;
        end else if (b >= 8'hE0) begin
            n = 3'd2;
        end else if (b >= 8'hC0) begin
            n = 3'd1;
        end else begin
            n = 3'd0;
        end
        return n;
    endfunction

endpackage

/* design/ted_step.sv */
// ----------------------------------------------------------------------------
// ted_step
// Per-byte scan update and end-of-buffer verdict, purely combinational.
// ----------------------------------------------------------------------------
module ted_step (
    input  ted_pkg::t_scan i_scan,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    output ted_pkg::t_scan o_scan,
    output ted_pkg::t_enc  o_enc
);
    import ted_pkg::*;

    t_scan      upd;
    logic [2:0] lead_n;

    always_comb begin
        upd    = i_scan;
        lead_n = cont_for_lead(i_byte);

        unique case (i_scan.count)
            3'd0:    upd.lead0 = i_byte;
            3'd1:    upd.lead1 = i_byte;
            3'd2:    upd.lead2 = i_byte;
            default: ;
        endcase
        if (i_scan.count < COUNT_SAT) begin
            upd.count = i_scan.count + 3'd1;
        end

        // once an error is seen the UTF-8 check state freezes
        if (!i_scan.invalid) begin
            if (i_byte[7]) begin
                upd.all_ascii = 1'b0;
            end
            if (i_scan.pend == 3'd0) begin
                if (i_byte[7]) begin
                    if (lead_n == 3'd0) begin
                        upd.invalid = 1'b1;
                    end else begin
                        upd.pend = lead_n;
                    end
                end
            end else begin
                if (i_byte[7:6] != 2'b10) begin
                    upd.invalid = 1'b1;
                end else begin
                    upd.pend = i_scan.pend - 3'd1;
                end
            end
        end
    end

    always_comb begin
        priority if (upd.count >= 3'd3 && upd.lead0 == 8'hFF && upd.lead1 == 8'hFE) begin
            o_enc = ENC_UTF16_LE;
        end else if (upd.count >= 3'd3 && upd.lead0 == 8'hFE && upd.lead1 == 8'hFF) begin
            o_enc = ENC_UTF16_BE;
        end else if (upd.count >= COUNT_SAT && upd.lead0 == 8'hEF &&
                     upd.lead1 == 8'hBB && upd.lead2 == 8'hBF) begin
            o_enc = ENC_UTF8_BOM;
        end else if (upd.invalid || upd.pend != 3'd0 || upd.all_ascii) begin
            o_enc = ENC_ANSI;
        end else begin
            o_enc = ENC_UTF8;
        end
    end

    // the final byte closes the buffer
    assign o_scan = i_last ? SCAN_RST : upd;

endmodule

/* design/text_encoding_detector.sv */
// A final byte passes the input register, then the result register, before its
// verdict is valid; a stall on the result side can delay it further.
// Throughput: one byte per cycle unless a final byte is held; the scan step is a single register stage.
// A final byte waits in the input register only while a prior verdict is held.
// Reset (synchronous, active low) empties both registers and clears the scan.
// ----------------------------------------------------------------------------
// text_encoding_detector
// Scans a byte stream for BOMs and UTF-8 structure, one verdict per buffer.
// ----------------------------------------------------------------------------
module text_encoding_detector (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_encoding
);
    import ted_pkg::*;

    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;
    t_scan      r_scan;
    t_scan      n_scan;
    t_enc       n_enc;
    logic       r_out_valid;
    t_enc       r_out_enc;

    logic out_free;
    logic s1_adv;
    logic s1_load;

    ted_step u_step (
        .i_scan (r_scan),
        .i_byte (r_s1_byte),
        .i_last (r_s1_last),
        .o_scan (n_scan),
        .o_enc  (n_enc)
    );

    // non-final bytes never need the result register
    assign out_free = !r_out_valid || !i_stall;
    assign s1_adv   = r_s1_valid && (!r_s1_last || out_free);
    assign s1_load  = !r_s1_valid || s1_adv;
    assign o_stall  = !s1_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_scan      <= SCAN_RST;
        end else begin
            if (s1_load) begin
                r_s1_valid <= i_valid;
            end
            if (s1_adv) begin
                r_scan <= n_scan;
            end
            if (s1_adv && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_byte <= i_data_byte;
            r_s1_last <= i_last_byte;
        end
        if (s1_adv && r_s1_last) begin
            r_out_enc <= n_enc;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_encoding = r_out_enc;

endmodule

/* design/ted_checker.sv */
// ----------------------------------------------------------------------------
// ted_checker
// Port-level checks for the encoding detector, bound to the top level.
// ----------------------------------------------------------------------------
module ted_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [2:0] o_encoding
);
    import ted_pkg::*;

    // a held verdict does not change
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_encoding))
        else $error("verdict changed while stalled");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_encoding == ENC_ANSI || o_encoding == ENC_UTF8 ||
                     o_encoding == ENC_UTF8_BOM || o_encoding == ENC_UTF16_LE ||
                     o_encoding == ENC_UTF16_BE))
        else $error("verdict code out of range");

    // input only backs up behind a held verdict
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty result register");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind text_encoding_detector ted_checker u_ted_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_encoding (o_encoding)
);

/* test/text_encoding_detector_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_encoding_detector_test
// Sends byte buffers through the encoding detector: first a directed set of
// BOM and UTF-8 edge cases, then random buffers that are mostly well-formed
// UTF-8 with optional BOM prefixes and some corruption or noise. Each input
// transfer also goes through a scoreboard with its own model of the detector.
// That scoreboard checks every verdict in order.
// Both handshakes idle at random under two of three profiles; the third never idles.
// ----------------------------------------------------------------------------
module text_encoding_detector_test;

    import ted_pkg::*;

    // Predicts one verdict per buffer and checks the detector against it
    class verdict_scoreboard;
        t_enc       expected_verdicts[$];
        int         errors;
        int         buffers;
        int         bytes_in;
        int         verdict_hist[5];
        logic [2:0] owed;
        bit         ascii_only;
        bit         broken;
        logic [7:0] head[3];
        int         taken;

        function new();
            errors   = 0;
            buffers  = 0;
            bytes_in = 0;
            foreach (verdict_hist[k]) verdict_hist[k] = 0;
            restart();
        endfunction

        function void restart();
            owed       = 3'd0;
            ascii_only = 1'b1;
            broken     = 1'b0;
            head[0]    = 8'h00;
            head[1]    = 8'h00;
            head[2]    = 8'h00;
            taken      = 0;
        endfunction

        function logic [2:0] lead_continuations(input logic [7:0] b);
            logic [2:0] n;
            casez (b)
                8'b1111_110?: n = 3'd5;
                8'b1111_1???: n = 3'd4;    // F8-FB and FE-FF
                8'b1111_0???: n = 3'd3;
                8'b1110_????: n = 3'd2;
                8'b110?_????: n = 3'd1;
                default:      n = 3'd0;
            endcase
            return n;
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction

        function void note_byte(input logic [7:0] b, input logic is_last);
            logic [2:0] n;
            t_enc       verdict;
            bytes_in++;
            if (taken < 3) head[taken] = b;
            if (taken < 4) taken++;
            // once the UTF-8 check has failed it stops tracking
            if (!broken) begin
                if (b[7]) ascii_only = 1'b0;
                if (owed == 3'd0) begin
                    if (b[7]) begin
                        n = lead_continuations(b);
                        if (n == 3'd0) broken = 1'b1;
                        else owed = n;
                    end
                end else if (b[7:6] != 2'b10) begin
                    broken = 1'b1;
                end else begin
                    owed = owed - 3'd1;
                end
            end
            if (!is_last) return;
            if (taken >= 3 && head[0] == 8'hFF && head[1] == 8'hFE)
                verdict = ENC_UTF16_LE;
            else if (taken >= 3 && head[0] == 8'hFE && head[1] == 8'hFF)
                verdict = ENC_UTF16_BE;
            else if (taken >= 4 && head[0] == 8'hEF && head[1] == 8'hBB && head[2] == 8'hBF)
                verdict = ENC_UTF8_BOM;
            else if (broken || owed != 3'd0 || ascii_only)
                verdict = ENC_ANSI;
            else
                verdict = ENC_UTF8;
            expected_verdicts.push_back(verdict);
            buffers++;
            restart();
        endfunction

        function void check_verdict(input logic [2:0] enc);
            t_enc want;
            if (expected_verdicts.size() == 0) begin
                $error("o_encoding: no verdict expected, actual %0d", enc);
                errors++;
                return;
            end
            want = expected_verdicts.pop_front();
            if (enc !== want) begin
                $error("o_encoding: expected %0d, actual %0d", want, enc);
                errors++;
            end
            if (want <= ENC_UTF16_BE) verdict_hist[want]++;
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_last_byte = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [2:0] o_encoding;

    verdict_scoreboard sb = new();
    logic [7:0]        buf_bytes[$];
    int                send_idle_pct = 22;
    int                recv_idle_pct = 76;

    text_encoding_detector uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_encoding  (o_encoding)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("text_encoding_detector_test failed");
        $finish;
    end

    // Result side: check on each transfer, then pick the next stall value
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_verdict(o_encoding);
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= is_last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_byte(b, is_last);
    endtask

    task automatic send_buffer();
        for (int k = 0; k < buf_bytes.size(); k++)
            send_byte(buf_bytes[k], k == buf_bytes.size() - 1);
    endtask

    // Hold off the sender until every verdict has come back
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic build_random_buffer();
        int         mode;
        int         n_cont;
        int         pos;
        logic [7:0] lead;
        buf_bytes.delete();
        mode = $urandom_range(99);
        if (mode < 10) begin
            // plain noise
            repeat ($urandom_range(8, 1)) buf_bytes.push_back(8'($urandom));
            return;
        end
        case ($urandom_range(9))
            0: begin
                buf_bytes.push_back(8'hFF);
                buf_bytes.push_back(8'hFE);
            end
            1: begin
                buf_bytes.push_back(8'hFE);
                buf_bytes.push_back(8'hFF);
            end
            2, 3: begin
                buf_bytes.push_back(8'hEF);
                buf_bytes.push_back(8'hBB);
                buf_bytes.push_back(8'hBF);
            end
            default: ;
        endcase
        repeat ($urandom_range(6, 0)) begin
            if ($urandom_range(2) == 0) begin
                buf_bytes.push_back(8'($urandom_range(8'h7F, 8'h00)));
            end else begin
                n_cont = $urandom_range(5, 1);
                case (n_cont)
                    1: lead = 8'($urandom_range(8'hDF, 8'hC0));
                    2: lead = 8'($urandom_range(8'hEF, 8'hE0));
                    3: lead = 8'($urandom_range(8'hF7, 8'hF0));
                    4: lead = $urandom_range(1) ? 8'($urandom_range(8'hFB, 8'hF8))
                                                : 8'($urandom_range(8'hFF, 8'hFE));
                    default: lead = 8'($urandom_range(8'hFD, 8'hFC));
                endcase
                buf_bytes.push_back(lead);
                repeat (n_cont) buf_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
            end
        end
        if (buf_bytes.size() == 0) buf_bytes.push_back(8'($urandom));
        // corrupt a byte or cut the tail
        if (mode < 25) begin
            pos = $urandom_range(buf_bytes.size() - 1, 0);
            if ($urandom_range(1) || buf_bytes.size() == 1) buf_bytes[pos] = 8'($urandom);
            else void'(buf_bytes.pop_back());
        end
    endtask

    initial begin
        int phase_bytes;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        buf_bytes = '{8'h00};                          send_buffer();
        buf_bytes = '{8'hFF, 8'hFE, 8'h41};            send_buffer();
        buf_bytes = '{8'hFE, 8'hFF};                   send_buffer();  // too short for BOM
        buf_bytes = '{8'hFE, 8'hFF, 8'h00};            send_buffer();
        buf_bytes = '{8'hEF, 8'hBB, 8'hBF};            send_buffer();  // too short for BOM
        buf_bytes = '{8'hEF, 8'hBB, 8'hBF, 8'h7F};     send_buffer();
        buf_bytes = '{8'hC3, 8'hA9};                   send_buffer();
        buf_bytes = '{8'h80, 8'hC3, 8'hA9};            send_buffer();  // stray, then sticky
        buf_bytes = '{8'hE2, 8'h82};                   send_buffer();  // unfinished
        buf_bytes = '{8'hC3, 8'h41};                   send_buffer();  // bad continuation
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle_pct = 22; recv_idle_pct = 76; end
                1: begin send_idle_pct = 76; recv_idle_pct = 22; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            phase_bytes = 0;
            while (phase_bytes < 400) begin
                build_random_buffer();
                phase_bytes += buf_bytes.size();
                send_buffer();
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        $display("Ran %0d buffers, %0d bytes, across three idling profiles",
                 sb.buffers, sb.bytes_in);
        $display("Verdicts seen: ANSI %0d, UTF-8 %0d, UTF-8 BOM %0d, UTF-16 LE %0d, UTF-16 BE %0d",
                 sb.verdict_hist[ENC_ANSI], sb.verdict_hist[ENC_UTF8],
                 sb.verdict_hist[ENC_UTF8_BOM], sb.verdict_hist[ENC_UTF16_LE],
                 sb.verdict_hist[ENC_UTF16_BE]);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("text_encoding_detector_test passed");
        else
            $display("text_encoding_detector_test failed");
        $finish;
    end

endmodule
